// ----- hdl/text_console_writer_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Check prop in the same cycle as cond.
`define TCW_ASSERT_NOW(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("text console writer check failed");

// Check prop in the cycle after cond.
`define TCW_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("text console writer check failed");

`endif

// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int COLX_W = ((COL_W > 3) ? COL_W : 3) + 1;
	localparam int ROWX_W = ROW_W + 2;
	localparam int CELLX_W = $clog2(COLUMNS * ROWS);

	localparam int OPCODE_W = 2;
	localparam int CHAR_W = 8;
	localparam int GCOL_W = 7;
	localparam int GROW_W = 5;
	localparam int CELL_W = 11;
	localparam int TAB_CELLS = 4;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [GCOL_W-1:0] gcol_t;
	typedef logic [GROW_W-1:0] grow_t;
	typedef logic [GROW_W:0] growx_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [COLX_W-1:0] colx_t;
	typedef logic [ROWX_W-1:0] rowx_t;
	typedef logic [CELLX_W-1:0] cellx_t;
	typedef logic [CELL_W-1:0] cell_t;

	localparam opcode_t OP_STREAM = 2'd0;
	localparam opcode_t OP_GOTO = 2'd1;
	localparam opcode_t OP_BACKSPACE = 2'd2;
	localparam opcode_t OP_RESERVED = 2'd3;

	localparam char_t CH_TAB = 8'd9;
	localparam char_t CH_NEWLINE = 8'd10;
	localparam char_t CH_ESCAPE = 8'd27;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t COLOUR_RESET = 8'h07;

	typedef struct packed {
		row_t row;
		col_t col;
		char_t colour;
		logic esc;
	} tcw_state_t;

	typedef struct packed {
		logic we;
		logic awe;
		cell_t wcell;
		char_t wchar;
		char_t attr;
		cell_t cursor;
		logic scroll;
	} tcw_result_t;

	function automatic cellx_t cell_of(input row_t r, input col_t c);
		return cellx_t'(r) * cellx_t'(COLUMNS) + cellx_t'(c);
	endfunction

endpackage

// ----- hdl/text_console_writer_core.sv -----
// Text console writer for a character grid.
// Input channel (in_valid, in_stall): one transaction per opcode: a stream
// byte (printable, newline, tab, escape or colour), a goto or a backspace.
// Output channel (out_valid, out_stall): exactly one result transaction per
// input transaction, in order: the cell write for the display memory, the
// cursor cell after the item, and a scroll pulse when the display memory
// must move its rows up by one.
// Latency: the result is valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle; the cursor and colour registers are
// updated at acceptance, so consecutive items see each other's effect.
// The result register decouples the channels: a new input is taken whenever
// the result register is empty or being emptied in the same cycle.
// A stall on the output holds the result and stalls the input only once the
// result register is full.
// Reset clears the cursor to cell 0, sets the colour to 7, drops a pending
// escape and empties the result register.
module text_console_writer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  tcw_pkg::opcode_t          opcode,
	input  tcw_pkg::char_t            char_byte,
	input  tcw_pkg::gcol_t            goto_col,
	input  tcw_pkg::grow_t            goto_row,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      write_enable,
	output logic                      attr_write_enable,
	output tcw_pkg::cell_t            write_cell,
	output tcw_pkg::char_t            write_char,
	output tcw_pkg::char_t            write_attr,
	output tcw_pkg::cell_t            cursor_cell,
	output logic                      scroll_up
);

	tcw_pkg::tcw_state_t state_q;
	tcw_pkg::tcw_state_t state_nxt;
	tcw_pkg::tcw_result_t res_nxt;
	tcw_pkg::tcw_result_t res_s1;
	logic out_valid_q;
	logic in_accept;

	assign in_stall = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	tcw_step u_step (
		.cur       (state_q),
		.opcode    (opcode),
		.char_byte (char_byte),
		.goto_col  (goto_col),
		.goto_row  (goto_row),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{row: '0, col: '0, colour: tcw_pkg::COLOUR_RESET, esc: 1'b0};
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_s1 <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign write_enable = res_s1.we;
	assign attr_write_enable = res_s1.awe;
	assign write_cell = res_s1.wcell;
	assign write_char = res_s1.wchar;
	assign write_attr = res_s1.attr;
	assign cursor_cell = res_s1.cursor;
	assign scroll_up = res_s1.scroll;

endmodule

// ----- hdl/tcw_step.sv -----
module tcw_step (
	input  tcw_pkg::tcw_state_t  cur,
	input  tcw_pkg::opcode_t     opcode,
	input  tcw_pkg::char_t       char_byte,
	input  tcw_pkg::gcol_t       goto_col,
	input  tcw_pkg::grow_t       goto_row,
	output tcw_pkg::tcw_state_t  nxt,
	output tcw_pkg::tcw_result_t res
);

	logic is_newline;
	logic is_tab;
	tcw_pkg::cellx_t cur_cell;
	tcw_pkg::colx_t adv_delta;
	tcw_pkg::colx_t adv_col0;
	tcw_pkg::colx_t adv_col1;
	tcw_pkg::colx_t adv_col2;
	logic adv_w1;
	logic adv_w2;
	tcw_pkg::rowx_t adv_row;
	logic adv_scroll;
	tcw_pkg::row_t adv_row_n;
	tcw_pkg::col_t adv_col_n;
	logic at_zero;
	tcw_pkg::row_t bs_row;
	tcw_pkg::col_t bs_col;
	tcw_pkg::row_t goto_row_c;
	tcw_pkg::col_t goto_col_c;

	assign is_newline = (char_byte == tcw_pkg::CH_NEWLINE);
	assign is_tab = (char_byte == tcw_pkg::CH_TAB);
	assign cur_cell = tcw_pkg::cell_of(cur.row, cur.col);

	assign adv_delta = is_tab ? tcw_pkg::colx_t'(tcw_pkg::TAB_CELLS) : tcw_pkg::colx_t'(1);
	assign adv_col0 = tcw_pkg::colx_t'(cur.col) + adv_delta;
	assign adv_w1 = (adv_col0 >= tcw_pkg::colx_t'(tcw_pkg::COLUMNS));
	assign adv_col1 = adv_w1 ? adv_col0 - tcw_pkg::colx_t'(tcw_pkg::COLUMNS) : adv_col0;
	assign adv_w2 = (adv_col1 >= tcw_pkg::colx_t'(tcw_pkg::COLUMNS));
	assign adv_col2 = adv_w2 ? adv_col1 - tcw_pkg::colx_t'(tcw_pkg::COLUMNS) : adv_col1;

	assign adv_row = tcw_pkg::rowx_t'(cur.row) + (is_newline ? tcw_pkg::rowx_t'(1)
		: tcw_pkg::rowx_t'(adv_w1) + tcw_pkg::rowx_t'(adv_w2));
	assign adv_scroll = (adv_row >= tcw_pkg::rowx_t'(tcw_pkg::ROWS));
	assign adv_row_n = adv_scroll ? tcw_pkg::row_t'(tcw_pkg::ROWS - 1) : tcw_pkg::row_t'(adv_row);
	assign adv_col_n = (adv_scroll || is_newline) ? '0 : tcw_pkg::col_t'(adv_col2);

	assign at_zero = (cur.row == '0) && (cur.col == '0);
	assign bs_col = (cur.col != '0) ? cur.col - tcw_pkg::col_t'(1)
		: tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1);
	assign bs_row = (cur.col != '0) ? cur.row : cur.row - tcw_pkg::row_t'(1);

	assign goto_col_c = (goto_col > tcw_pkg::gcol_t'(tcw_pkg::COLUMNS - 1))
		? tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1) : tcw_pkg::col_t'(goto_col);
	assign goto_row_c = (tcw_pkg::growx_t'(goto_row) > tcw_pkg::growx_t'(tcw_pkg::ROWS - 1))
		? tcw_pkg::row_t'(tcw_pkg::ROWS - 1) : tcw_pkg::row_t'(goto_row);

	always_comb begin
		nxt = cur;
		res = '0;
		case (opcode)
			tcw_pkg::OP_STREAM: begin
				if (cur.esc) begin
					nxt.colour = char_byte;
					nxt.esc = 1'b0;
				end else if (char_byte == tcw_pkg::CH_ESCAPE) begin
					nxt.esc = 1'b1;
				end else begin
					if (!is_newline && !is_tab) begin
						res.we = 1'b1;
						res.awe = 1'b1;
						res.wcell = tcw_pkg::cell_t'(cur_cell);
						res.wchar = char_byte;
						res.attr = cur.colour;
					end
					nxt.row = adv_row_n;
					nxt.col = adv_col_n;
					res.scroll = adv_scroll;
				end
			end
			tcw_pkg::OP_GOTO: begin
				nxt.row = goto_row_c;
				nxt.col = goto_col_c;
			end
			tcw_pkg::OP_BACKSPACE: begin
				if (!at_zero) begin
					nxt.row = bs_row;
					nxt.col = bs_col;
					res.we = 1'b1;
					res.wcell = tcw_pkg::cell_t'(cur_cell - tcw_pkg::cellx_t'(1));
					res.wchar = tcw_pkg::CH_SPACE;
				end
			end
			default: begin
			end
		endcase
		res.cursor = tcw_pkg::cell_t'(tcw_pkg::cell_of(nxt.row, nxt.col));
	end

endmodule

// ----- hdl/tcw_checker.sv -----
`include "text_console_writer_core_macros.svh"

module tcw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input logic           write_enable,
	input logic           attr_write_enable,
	input tcw_pkg::cell_t write_cell,
	input tcw_pkg::cell_t cursor_cell,
	input logic           scroll_up
);

	localparam tcw_pkg::cell_t LAST_ROW_CELL =
		tcw_pkg::cell_t'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);

	`TCW_ASSERT_NEXT(a_accept_gives_result, in_valid && !in_stall, out_valid)
	`TCW_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)
	`TCW_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall, out_valid && $stable(cursor_cell) && $stable(write_cell))
	`TCW_ASSERT_NOW(a_scroll_lands_last_row, out_valid && scroll_up, cursor_cell == LAST_ROW_CELL && !(write_enable && !attr_write_enable))

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
